@@ sv/nbrp_pkg.sv @@
// Shared types and constants for the nonzero-balanced row partitioner.
// Used by the controller, the datapath and the top level; depends on nothing.
package nbrp_pkg;

  // Default sizing of the block.
  localparam int DEF_MAX_PARTITIONS = 1024;
  localparam int DEF_POINTER_BITS   = 31;

  // Width of the partition_total register as written on the configuration port.
  localparam int PART_CFG_W = 11;

  // Configuration register indexes.
  localparam logic CFG_PARTITION_TOTAL = 1'b0;
  localparam logic CFG_TOTAL_NONZEROS  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_FIN = 3'b100
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic div_step;  // one restoring-division step
    logic div_fin;   // load the new target from the quotient
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic close;     // the item on the input closes a partition
    logic div_req;   // the item on the input needs a new target
  } sts_t;

endpackage

@@ sv/nnz_balanced_row_partitioner_core.sv @@
// Top level of the nonzero-balanced CSR row partitioner: stream ports and the
// configuration port around nbrp_ctrl and nbrp_datapath. Depends on nbrp_pkg.
//
// The block takes the row-pointer array of a CSR matrix, one entry per transfer,
// and cuts the rows greedily into partition_total partitions of balanced nonzero
// count. A pass opens on an entry flagged in in_tuser (entry zero) and ends on the
// entry marked by in_tlast or when the last partition closes; entries outside a
// pass are consumed and ignored. Each partition's target is its start pointer plus
// the remaining nonzeros divided by the remaining partitions; when an entry reaches
// the target, the boundary goes to the closer side and one result transfer gives
// the partition's index, row count and nonzero count, with out_tlast set when it
// closed on the final entry. Ordinary entries are taken one per cycle unless the
// output stalls. The opening entry, and every closing entry that leaves partitions
// open, starts a serial restoring divider that produces one quotient bit per cycle;
// in_tready stays low until DIV steps and FIN load the new target. A result waits in
// an output register; a new entry is taken in the cycle that the result leaves or
// once it has gone. The user must write configuration only while the block is idle;
// the block does not enforce this. It takes effect at the next opening entry.
module nnz_balanced_row_partitioner_core import nbrp_pkg::*; #(
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int POINTER_BITS   = DEF_POINTER_BITS,
  parameter int IDX_W          = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
  parameter int CFG_W          = (POINTER_BITS > PART_CFG_W) ? POINTER_BITS : PART_CFG_W,
  parameter int IN_TDATA_W     = ((POINTER_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W    = ((IDX_W + 2 * POINTER_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Row-pointer input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pointer_value, zero padding
  input  logic                   in_tuser,   // is_first
  input  logic                   in_tlast,   // last_row
  // Partition result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // partition_index, rows_in_partition,
                                             // nonzeros_in_partition, zero padding
  output logic                   out_tlast   // final_flag
);

  cmd_t cmd;
  sts_t sts;

  logic [IDX_W-1:0]        partition_index;
  logic [POINTER_BITS-1:0] rows_in_partition;
  logic [POINTER_BITS-1:0] nonzeros_in_partition;

  nbrp_ctrl #(
    .POINTER_BITS (POINTER_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nbrp_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .POINTER_BITS   (POINTER_BITS),
    .IDX_W          (IDX_W),
    .CFG_W          (CFG_W)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .pointer_value         (in_tdata[POINTER_BITS-1:0]),
    .is_first              (in_tuser),
    .last_row              (in_tlast),
    .cmd                   (cmd),
    .sts                   (sts),
    .partition_index       (partition_index),
    .rows_in_partition     (rows_in_partition),
    .nonzeros_in_partition (nonzeros_in_partition),
    .final_flag            (out_tlast)
  );

  // Fields packed from the lowest bit up; the padding reads as zero.
  assign out_tdata = OUT_TDATA_W'({nonzeros_in_partition, rows_in_partition, partition_index});

endmodule

@@ sv/nbrp_ctrl.sv @@
// Controller state machine of the row partitioner: handshakes, division sequencing
// and the output valid flag. Depends on nbrp_pkg.
module nbrp_ctrl import nbrp_pkg::*; #(
  parameter int POINTER_BITS = DEF_POINTER_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(POINTER_BITS);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;

  // A new item is taken only when the output register is free or drains now.
  assign in_tready  = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.div_fin  = (state_r == ST_FIN);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_RUN: begin
        cnt_nxt = '0;
        if (accept && sts.div_req) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(POINTER_BITS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && sts.close) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/nbrp_datapath.sv @@
// Datapath of the row partitioner: configuration and pass registers, the boundary
// decision, the serial target divider and the result register. Depends on nbrp_pkg.
module nbrp_datapath import nbrp_pkg::*; #(
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int POINTER_BITS   = DEF_POINTER_BITS,
  parameter int IDX_W          = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1,
  parameter int CFG_W          = (POINTER_BITS > PART_CFG_W) ? POINTER_BITS : PART_CFG_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_addr,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic [POINTER_BITS-1:0] pointer_value,
  input  logic                    is_first,
  input  logic                    last_row,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [IDX_W-1:0]        partition_index,
  output logic [POINTER_BITS-1:0] rows_in_partition,
  output logic [POINTER_BITS-1:0] nonzeros_in_partition,
  output logic                    final_flag
);

  localparam int P       = POINTER_BITS;
  localparam int PARTS_W = $clog2(MAX_PARTITIONS + 1);

  // Configuration.
  logic [PART_CFG_W-1:0] parts_cfg_r;
  logic [P-1:0]          total_cfg_r;

  // Pass state.
  logic [P-1:0]       prev_r, prev_nxt;
  logic [P-1:0]       start_r, start_nxt;
  logic [P-1:0]       rows_r, rows_nxt;
  logic [P-1:0]       rem_nnz_r, rem_nnz_nxt;
  logic [PARTS_W-1:0] rem_parts_r, rem_parts_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [P:0]         target_r;

  // Divider.
  logic [P-1:0]       div_n_r;
  logic [PARTS_W-1:0] div_rem_r;
  logic [PARTS_W:0]   div_sh;
  logic               div_qbit;

  // Result register.
  logic [IDX_W-1:0] res_idx_r;
  logic [P-1:0]     res_rows_r;
  logic [P-1:0]     res_nnz_r;
  logic             res_final_r;

  logic               active, ge, after, close;
  logic [P-1:0]       rows_inc, nnz, out_rows;
  logic [PARTS_W-1:0] parts_clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parts_cfg_r <= PART_CFG_W'(1);
      total_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PARTITION_TOTAL: parts_cfg_r <= cfg_wdata[PART_CFG_W-1:0];
        CFG_TOTAL_NONZEROS:  total_cfg_r <= cfg_wdata[P-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    if (parts_cfg_r == '0) begin
      parts_clamped = PARTS_W'(1);
    end else if (32'(parts_cfg_r) > 32'(MAX_PARTITIONS)) begin
      parts_clamped = PARTS_W'(MAX_PARTITIONS);
    end else begin
      parts_clamped = PARTS_W'(parts_cfg_r);
    end
  end

  // Boundary decision. Overshoot no larger than the shortfall is p1 + p0 <= 2 * target.
  assign active   = (rem_parts_r != '0);
  assign rows_inc = rows_r + 1'b1;
  assign ge       = ({1'b0, pointer_value} >= target_r);
  assign after    = ({1'b0, prev_r} <= target_r) &&
                    (({3'b000, pointer_value} + {3'b000, prev_r}) <= {1'b0, target_r, 1'b0});
  assign close    = !is_first && active && ge;
  assign nnz      = after ? (pointer_value - start_r) : (prev_r - start_r);
  assign out_rows = after ? rows_inc : rows_r;

  assign sts.close   = close;
  assign sts.div_req = is_first || (close && !last_row && (rem_parts_r != PARTS_W'(1)));

  always_comb begin
    prev_nxt      = prev_r;
    start_nxt     = start_r;
    rows_nxt      = rows_r;
    rem_nnz_nxt   = rem_nnz_r;
    rem_parts_nxt = rem_parts_r;
    cur_nxt       = cur_r;
    if (is_first) begin
      prev_nxt      = pointer_value;
      start_nxt     = pointer_value;
      rows_nxt      = '0;
      rem_nnz_nxt   = total_cfg_r;
      rem_parts_nxt = parts_clamped;
      cur_nxt       = '0;
    end else if (active) begin
      prev_nxt = pointer_value;
      if (ge) begin
        start_nxt     = after ? pointer_value : prev_r;
        rows_nxt      = after ? P'(0) : P'(1);
        rem_nnz_nxt   = (nnz > rem_nnz_r) ? P'(0) : (rem_nnz_r - nnz);
        rem_parts_nxt = rem_parts_r - 1'b1;
        cur_nxt       = cur_r + 1'b1;
      end else begin
        rows_nxt = rows_inc;
      end
      if (last_row) begin
        rem_parts_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      start_r     <= '0;
      rows_r      <= '0;
      rem_nnz_r   <= '0;
      rem_parts_r <= '0;
      cur_r       <= '0;
      target_r    <= '0;
    end else begin
      if (cmd.accept) begin
        prev_r      <= prev_nxt;
        start_r     <= start_nxt;
        rows_r      <= rows_nxt;
        rem_nnz_r   <= rem_nnz_nxt;
        rem_parts_r <= rem_parts_nxt;
        cur_r       <= cur_nxt;
      end
      if (cmd.div_fin) begin
        target_r <= {1'b0, start_r} + {1'b0, div_n_r};
      end
    end
  end

  // Restoring division, one quotient bit per step; quotient bits replace the dividend.
  assign div_sh   = {div_rem_r, div_n_r[P-1]};
  assign div_qbit = (div_sh >= {1'b0, rem_parts_r});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_n_r   <= rem_nnz_nxt;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_n_r   <= {div_n_r[P-2:0], div_qbit};
      div_rem_r <= div_qbit ? PARTS_W'(div_sh - {1'b0, rem_parts_r}) : div_sh[PARTS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && close) begin
      res_idx_r   <= cur_r;
      res_rows_r  <= out_rows;
      res_nnz_r   <= nnz;
      res_final_r <= last_row;
    end
  end

  assign partition_index       = res_idx_r;
  assign rows_in_partition     = res_rows_r;
  assign nonzeros_in_partition = res_nnz_r;
  assign final_flag            = res_final_r;

endmodule

@@ sv/nbrp_checker.sv @@
// Port-level checker for the row partitioner, bound to the top level.
// Depends only on the top level's ports.
module nbrp_checker #(
  parameter int IN_TDATA_W  = 32,
  parameter int OUT_TDATA_W = 72
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // An offered entry that is not yet taken holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser) &&
                                $stable(in_tlast))
    else $error("input entry changed while stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A result appears only after an input transfer.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without an input transfer");

  // An opening entry never produces a result.
  a_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !$rose(out_tvalid))
    else $error("result from an opening entry");

  // An opening entry starts the divider, so the next entry must wait.
  a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken while the target is computed");

endmodule

bind nnz_balanced_row_partitioner_core nbrp_checker #(
  .IN_TDATA_W  (IN_TDATA_W),
  .OUT_TDATA_W (OUT_TDATA_W)
) u_nbrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
